// ===== hw/rtl/hptp_pkg.sv =====
// Shared token codes, record codes and result attribute type for the header parser.
package hptp_pkg;

   localparam int TAG_BITS_DEF = 16;
   localparam int INT_BITS_DEF = 32;
   localparam int KIND_BITS    = 5;
   localparam int RANGE_BITS   = 32;

   localparam logic [KIND_BITS-1:0] TK_MODULE   = 5'd0;
   localparam logic [KIND_BITS-1:0] TK_IDENT    = 5'd1;
   localparam logic [KIND_BITS-1:0] TK_INT      = 5'd2;
   localparam logic [KIND_BITS-1:0] TK_LPAREN   = 5'd3;
   localparam logic [KIND_BITS-1:0] TK_RPAREN   = 5'd4;
   localparam logic [KIND_BITS-1:0] TK_LBRACK   = 5'd5;
   localparam logic [KIND_BITS-1:0] TK_RBRACK   = 5'd6;
   localparam logic [KIND_BITS-1:0] TK_COLON    = 5'd7;
   localparam logic [KIND_BITS-1:0] TK_COMMA    = 5'd8;
   localparam logic [KIND_BITS-1:0] TK_SEMI     = 5'd9;
   localparam logic [KIND_BITS-1:0] TK_INPUT    = 5'd10;
   localparam logic [KIND_BITS-1:0] TK_INOUT    = 5'd12;
   localparam logic [KIND_BITS-1:0] TK_NET_BASE = 5'd12;
   localparam logic [KIND_BITS-1:0] TK_SUPPLY0  = 5'd13;
   localparam logic [KIND_BITS-1:0] TK_WOR      = 5'd23;
   localparam logic [KIND_BITS-1:0] TK_SIGNED   = 5'd24;
   localparam logic [KIND_BITS-1:0] TK_UNSIGNED = 5'd25;
   localparam logic [KIND_BITS-1:0] TK_BIT      = 5'd26;
   localparam logic [KIND_BITS-1:0] TK_REG      = 5'd28;

   localparam logic [1:0] REC_MODULE   = 2'd0;
   localparam logic [1:0] REC_PORT     = 2'd1;
   localparam logic [1:0] REC_COMPLETE = 2'd2;
   localparam logic [1:0] REC_ERROR    = 2'd3;

   localparam logic [1:0] DIR_INOUT = 2'd2;

   typedef struct packed {
      logic [1:0] record_kind;
      logic [1:0] port_dir;
      logic [3:0] net_kind;
      logic [1:0] vector_kind;
      logic       is_signed;
      logic       has_range;
   } rsp_attr_type;

endpackage

// ===== hw/rtl/hptp_parser.sv =====
// Header grammar state machine with the declaration context and the result register.
module hptp_parser #(
   parameter int TAG_BITS = hptp_pkg::TAG_BITS_DEF,
   parameter int INT_BITS = hptp_pkg::INT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic [hptp_pkg::KIND_BITS-1:0]        token_kind,
   input  logic [INT_BITS-1:0]                   token_int,
   input  logic [TAG_BITS-1:0]                   token_tag,
   input  logic                                  rsp_stall,
   output logic                                  out_free,
   output logic                                  rsp_valid,
   output hptp_pkg::rsp_attr_type                rsp_attr,
   output logic [TAG_BITS-1:0]                   rsp_tag,
   output logic signed [hptp_pkg::RANGE_BITS-1:0] rsp_left,
   output logic signed [hptp_pkg::RANGE_BITS-1:0] rsp_right
);
   import hptp_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE, PH_SKIP, PH_NAME, PH_LPAREN, PH_FIRST, PH_NET, PH_DTYPE, PH_VSIGN,
      PH_RANGE_OPT, PH_R_LEFT, PH_R_COLON, PH_R_RIGHT, PH_R_CLOSE, PH_IDENT,
      PH_AFTER_ID, PH_AFTER_COMMA, PH_SEMI
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [1:0]          dir_ff, dir_in;
   logic [3:0]          net_ff, net_in;
   logic [1:0]          vec_ff, vec_in;
   logic                sgn_ff, sgn_in;
   logic                rng_ff, rng_in;
   logic [INT_BITS-1:0] left_ff, left_in;
   logic [INT_BITS-1:0] right_ff, right_in;

   logic                                rsp_valid_ff;
   rsp_attr_type                        attr_ff, attr_in;
   logic [TAG_BITS-1:0]                 tag_ff, tag_in;
   logic signed [RANGE_BITS-1:0]        left_out_ff, left_out_in;
   logic signed [RANGE_BITS-1:0]        right_out_ff, right_out_in;

   logic emit, err, port_rec, name_rec, done_rec;
   logic k_dir, k_net, k_vec, k_sign;

   assign k_dir  = (token_kind >= TK_INPUT) && (token_kind <= TK_INOUT);
   assign k_net  = (token_kind >= TK_SUPPLY0) && (token_kind <= TK_WOR);
   assign k_vec  = (token_kind >= TK_BIT) && (token_kind <= TK_REG);
   assign k_sign = (token_kind == TK_SIGNED) || (token_kind == TK_UNSIGNED);

   always_comb begin
      phase_in = phase_ff;
      dir_in   = dir_ff;
      net_in   = net_ff;
      vec_in   = vec_ff;
      sgn_in   = sgn_ff;
      rng_in   = rng_ff;
      left_in  = left_ff;
      right_in = right_ff;
      err      = 1'b0;
      port_rec = 1'b0;
      name_rec = 1'b0;
      done_rec = 1'b0;
      unique case (phase_ff)
         PH_IDLE, PH_SKIP: begin
            if (token_kind == TK_MODULE) begin
               phase_in = PH_NAME;
            end else if (phase_ff == PH_IDLE) begin
               err = 1'b1;
            end
         end
         PH_NAME: begin
            if (token_kind == TK_IDENT) begin
               phase_in = PH_LPAREN;
               name_rec = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         PH_LPAREN: begin
            if (token_kind == TK_LPAREN) phase_in = PH_FIRST;
            else err = 1'b1;
         end
         PH_NET, PH_DTYPE, PH_VSIGN, PH_RANGE_OPT: begin
            priority if (phase_ff == PH_NET && k_net) begin
               net_in   = 4'(token_kind - TK_NET_BASE);
               phase_in = PH_DTYPE;
            end else if ((phase_ff == PH_NET || phase_ff == PH_DTYPE) && k_vec) begin
               vec_in   = 2'(token_kind - TK_UNSIGNED);
               phase_in = PH_VSIGN;
            end else if (phase_ff != PH_RANGE_OPT && k_sign) begin
               sgn_in   = (token_kind == TK_SIGNED);
               phase_in = PH_RANGE_OPT;
            end else if (token_kind == TK_LBRACK) begin
               phase_in = PH_R_LEFT;
            end else if (token_kind == TK_IDENT) begin
               phase_in = PH_AFTER_ID;
               port_rec = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         PH_R_LEFT: begin
            if (token_kind == TK_INT) begin
               left_in  = token_int;
               phase_in = PH_R_COLON;
            end else begin
               err = 1'b1;
            end
         end
         PH_R_COLON: begin
            if (token_kind == TK_COLON) phase_in = PH_R_RIGHT;
            else err = 1'b1;
         end
         PH_R_RIGHT: begin
            if (token_kind == TK_INT) begin
               right_in = token_int;
               phase_in = PH_R_CLOSE;
            end else begin
               err = 1'b1;
            end
         end
         PH_R_CLOSE: begin
            if (token_kind == TK_RBRACK) begin
               rng_in   = 1'b1;
               phase_in = PH_IDENT;
            end else begin
               err = 1'b1;
            end
         end
         PH_IDENT: begin
            if (token_kind == TK_IDENT) begin
               phase_in = PH_AFTER_ID;
               port_rec = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         PH_FIRST, PH_AFTER_ID, PH_AFTER_COMMA: begin
            priority if (phase_ff == PH_AFTER_ID && token_kind == TK_COMMA) begin
               phase_in = PH_AFTER_COMMA;
            end else if (phase_ff != PH_AFTER_COMMA && token_kind == TK_RPAREN) begin
               phase_in = PH_SEMI;
            end else if (phase_ff == PH_AFTER_COMMA && token_kind == TK_IDENT) begin
               phase_in = PH_AFTER_ID;
               port_rec = 1'b1;
            end else if (k_dir) begin
               dir_in   = 2'(token_kind - TK_INPUT);
               net_in   = '0;
               vec_in   = '0;
               sgn_in   = 1'b0;
               rng_in   = 1'b0;
               left_in  = '0;
               right_in = '0;
               phase_in = PH_NET;
            end else begin
               err = 1'b1;
            end
         end
         PH_SEMI: begin
            if (token_kind == TK_SEMI) begin
               phase_in = PH_IDLE;
               done_rec = 1'b1;
            end else begin
               err = 1'b1;
            end
         end
         default: err = 1'b1;
      endcase
      if (err) phase_in = PH_SKIP;
   end

   assign emit = err | port_rec | name_rec | done_rec;

   always_comb begin
      attr_in      = '0;
      tag_in       = '0;
      left_out_in  = '0;
      right_out_in = '0;
      priority if (port_rec) begin
         attr_in.record_kind = REC_PORT;
         attr_in.port_dir    = dir_ff;
         attr_in.net_kind    = net_ff;
         attr_in.vector_kind = vec_ff;
         attr_in.is_signed   = sgn_ff;
         attr_in.has_range   = rng_ff;
         tag_in              = token_tag;
         left_out_in         = RANGE_BITS'($signed(left_ff));
         right_out_in        = RANGE_BITS'($signed(right_ff));
      end else if (name_rec) begin
         attr_in.record_kind = REC_MODULE;
         tag_in              = token_tag;
      end else if (done_rec) begin
         attr_in.record_kind = REC_COMPLETE;
      end else begin
         attr_in.record_kind = REC_ERROR;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         dir_ff       <= '0;
         net_ff       <= '0;
         vec_ff       <= '0;
         sgn_ff       <= 1'b0;
         rng_ff       <= 1'b0;
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            dir_ff   <= dir_in;
            net_ff   <= net_in;
            vec_ff   <= vec_in;
            sgn_ff   <= sgn_in;
            rng_ff   <= rng_in;
            left_ff  <= left_in;
            right_ff <= right_in;
         end
         if (step && emit) begin
            rsp_valid_ff <= 1'b1;
            attr_ff      <= attr_in;
            tag_ff       <= tag_in;
            left_out_ff  <= left_out_in;
            right_out_ff <= right_out_in;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_attr  = attr_ff;
   assign rsp_tag   = tag_ff;
   assign rsp_left  = left_out_ff;
   assign rsp_right = right_out_ff;

endmodule

// ===== hw/rtl/hdl_port_header_token_parser_top.sv =====
// Top level of the module header token parser: input register and parser.
//
// Takes one lexed token per cycle and emits module name, port, completion and
// syntax error records; a token yields zero or one record. Sustained rate is one
// token per clock while the result is not stalled. The accepted token sits in the
// token register, and the combinational grammar step updates the parse state and
// loads the result register that drives rsp_. A stalled result holds the token
// register, which then stalls req_.
module hdl_port_header_token_parser_top #(
   parameter int TAG_BITS = hptp_pkg::TAG_BITS_DEF,
   parameter int INT_BITS = hptp_pkg::INT_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [hptp_pkg::KIND_BITS-1:0]         req_token_kind,
   input  logic signed [hptp_pkg::RANGE_BITS-1:0] req_int_value,
   input  logic [TAG_BITS-1:0]                    req_ident_tag,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_record_kind,
   output logic [TAG_BITS-1:0]                    rsp_name_tag,
   output logic [1:0]                             rsp_port_dir,
   output logic [3:0]                             rsp_net_kind,
   output logic [1:0]                             rsp_vector_kind,
   output logic                                   rsp_is_signed,
   output logic                                   rsp_has_range,
   output logic signed [hptp_pkg::RANGE_BITS-1:0] rsp_range_left,
   output logic signed [hptp_pkg::RANGE_BITS-1:0] rsp_range_right
);
   import hptp_pkg::*;

   logic                 tok_valid_ff;
   logic [KIND_BITS-1:0] tok_kind_ff;
   logic [INT_BITS-1:0]  tok_int_ff;
   logic [TAG_BITS-1:0]  tok_tag_ff;
   logic                 out_free;
   logic                 step;
   logic                 req_take;
   rsp_attr_type         attr;

   assign step      = tok_valid_ff && out_free;
   assign req_stall = tok_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else if (req_take) begin
         tok_valid_ff <= 1'b1;
         tok_kind_ff  <= req_token_kind;
         tok_int_ff   <= req_int_value[INT_BITS-1:0];
         tok_tag_ff   <= req_ident_tag;
      end else if (step) begin
         tok_valid_ff <= 1'b0;
      end
   end

   hptp_parser #(
      .TAG_BITS(TAG_BITS),
      .INT_BITS(INT_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .token_kind (tok_kind_ff),
      .token_int  (tok_int_ff),
      .token_tag  (tok_tag_ff),
      .rsp_stall  (rsp_stall),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_attr   (attr),
      .rsp_tag    (rsp_name_tag),
      .rsp_left   (rsp_range_left),
      .rsp_right  (rsp_range_right)
   );

   assign rsp_record_kind = attr.record_kind;
   assign rsp_port_dir    = attr.port_dir;
   assign rsp_net_kind    = attr.net_kind;
   assign rsp_vector_kind = attr.vector_kind;
   assign rsp_is_signed   = attr.is_signed;
   assign rsp_has_range   = attr.has_range;

endmodule

// ===== hw/rtl/hptp_checker.sv =====
// Port-level assertions for the header parser, bound to the top level.
module hptp_port_asserts #(
   parameter int TAG_BITS = hptp_pkg::TAG_BITS_DEF
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [1:0]                             rsp_record_kind,
   input logic [TAG_BITS-1:0]                    rsp_name_tag,
   input logic [1:0]                             rsp_port_dir,
   input logic [3:0]                             rsp_net_kind,
   input logic [1:0]                             rsp_vector_kind,
   input logic                                   rsp_is_signed,
   input logic                                   rsp_has_range,
   input logic signed [hptp_pkg::RANGE_BITS-1:0] rsp_range_left,
   input logic signed [hptp_pkg::RANGE_BITS-1:0] rsp_range_right
);
   import hptp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_record_kind)
         && $stable(rsp_name_tag) && $stable(rsp_range_left))
      else $error("stalled rsp transaction changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp transaction right after reset");

   a_plain_records: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind != REC_PORT |-> rsp_port_dir == 2'd0
         && rsp_net_kind == 4'd0 && rsp_vector_kind == 2'd0 && !rsp_is_signed
         && !rsp_has_range)
      else $error("non-port record carries port attributes");

   a_tagless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind == REC_COMPLETE || rsp_record_kind == REC_ERROR)
         |-> rsp_name_tag == '0)
      else $error("complete or error record carries a tag");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_range |-> rsp_range_left == 0 && rsp_range_right == 0
         && rsp_port_dir <= DIR_INOUT)
      else $error("range bounds without range or bad direction");

endmodule

bind hdl_port_header_token_parser_top hptp_port_asserts #(.TAG_BITS(TAG_BITS)) u_hptp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_record_kind (rsp_record_kind),
   .rsp_name_tag    (rsp_name_tag),
   .rsp_port_dir    (rsp_port_dir),
   .rsp_net_kind    (rsp_net_kind),
   .rsp_vector_kind (rsp_vector_kind),
   .rsp_is_signed   (rsp_is_signed),
   .rsp_has_range   (rsp_has_range),
   .rsp_range_left  (rsp_range_left),
   .rsp_range_right (rsp_range_right)
);
